// ===== sv/sbpq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpq_pkg
// Shared types and constants for the shared block pool byte queues.
// ----------------------------------------------------------------------------
package sbpq_pkg;

  localparam int POOL_BLOCKS_DEF = 512;
  localparam int BLOCK_BYTES_DEF = 256;
  localparam int NUM_QUEUES_DEF  = 4;

  localparam int CMD_W  = 2;
  localparam int QID_W  = 2;
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_FLUSH,
    OP_STATUS
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              qok;
    logic [QID_W-1:0]  qid;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_W_RD,
    S_W_CHK,
    S_W_POP,
    S_W_STEAL,
    S_W_LINK,
    S_W_AGE,
    S_R_RD,
    S_R_CHK,
    S_R_DATA,
    S_F_RD,
    S_F_UPD,
    S_OUT
  } state_t;

endpackage

// ===== sv/sbpq_front.sv =====
// ----------------------------------------------------------------------------
// sbpq_front
// Accepts command transactions, decodes them and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module sbpq_front #(
  parameter int NUM_QUEUES = sbpq_pkg::NUM_QUEUES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sbpq_pkg::CMD_W-1:0]  cmd,
  input  logic [sbpq_pkg::QID_W-1:0]  queue_id,
  input  logic [sbpq_pkg::BYTE_W-1:0] write_byte,
  output logic                        item_valid,
  output sbpq_pkg::item_t             item,
  input  logic                        item_pop
);

  sbpq_pkg::item_t slot [2];
  sbpq_pkg::item_t dec;
  logic [1:0]      cnt;
  logic            rd_ptr;
  logic            wr_ptr;
  logic            push;

  assign in_stall   = (cnt == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt != 2'd0);
  assign item       = slot[rd_ptr];

  always_comb begin
    case (cmd)
      sbpq_pkg::CMD_WRITE: dec.op = sbpq_pkg::OP_WRITE;
      sbpq_pkg::CMD_READ:  dec.op = sbpq_pkg::OP_READ;
      sbpq_pkg::CMD_FLUSH: dec.op = sbpq_pkg::OP_FLUSH;
      default:             dec.op = sbpq_pkg::OP_STATUS;
    endcase
    dec.qok  = (int'(queue_id) < NUM_QUEUES);
    dec.qid  = queue_id;
    dec.data = write_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (item_pop) rd_ptr <= !rd_ptr;
      if (push && !item_pop) cnt <= cnt + 2'd1;
      else if (!push && item_pop) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= dec;
  end

endmodule

// ===== sv/sbpq_back.sv =====
// ----------------------------------------------------------------------------
// sbpq_back
// Sequencer that carries out queue commands on the block pool memories and
// presents one registered result per command.
// ----------------------------------------------------------------------------
module sbpq_back #(
  parameter int POOL_BLOCKS = sbpq_pkg::POOL_BLOCKS_DEF,
  parameter int BLOCK_BYTES = sbpq_pkg::BLOCK_BYTES_DEF,
  parameter int NUM_QUEUES  = sbpq_pkg::NUM_QUEUES_DEF,
  localparam int BW = $clog2(POOL_BLOCKS + 1),
  localparam int CW = $clog2(POOL_BLOCKS * BLOCK_BYTES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  sbpq_pkg::item_t             item,
  output logic                        item_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbpq_pkg::BYTE_W-1:0] read_byte,
  output logic                        read_valid,
  output logic [CW-1:0]               queue_avail,
  output logic [BW-1:0]               free_blocks,
  output logic                        queue_empty,
  output logic                        dropped_block
);

  localparam int XW  = $clog2(POOL_BLOCKS);
  localparam int PW  = $clog2(BLOCK_BYTES + 1);
  localparam int AW  = $clog2(POOL_BLOCKS * BLOCK_BYTES);
  localparam int OW  = $clog2(NUM_QUEUES + 1);
  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QN  = 1 << QIW;
  localparam logic [BW-1:0] NIL   = BW'(POOL_BLOCKS);
  localparam logic [BW-1:0] LAST  = BW'(POOL_BLOCKS - 1);
  localparam logic [PW-1:0] FULL  = PW'(BLOCK_BYTES);
  localparam logic [OW-1:0] UNOWN = OW'(NUM_QUEUES);

  sbpq_pkg::state_t state, state_next;
  sbpq_pkg::item_t  cur;

  logic [BW-1:0] clr;
  logic [BW-1:0] b;
  logic [BW-1:0] head [QN];
  logic [BW-1:0] tail [QN];
  logic [CW-1:0] cnt  [QN];
  logic [BW-1:0] fc;
  logic [BW-1:0] ftop;
  logic [BW-1:0] oldest;
  logic [BW-1:0] newest;
  logic          freeing;
  logic          dropped;
  logic          rvalid;
  logic [7:0]    rbyte;

  logic [PW-1:0] wpos_mem  [POOL_BLOCKS];
  logic [PW-1:0] rpos_mem  [POOL_BLOCKS];
  logic [OW-1:0] own_mem   [POOL_BLOCKS];
  logic [BW-1:0] qlink_mem [POOL_BLOCKS];
  logic [BW-1:0] anext_mem [POOL_BLOCKS];
  logic [BW-1:0] aprev_mem [POOL_BLOCKS];
  logic [BW-1:0] flink_mem [POOL_BLOCKS];
  logic [7:0]    store_mem [POOL_BLOCKS * BLOCK_BYTES];

  logic [PW-1:0] wpos_rd, rpos_rd;
  logic [OW-1:0] own_rd;
  logic [BW-1:0] qlink_rd, anext_rd, aprev_rd, flink_rd;
  logic [7:0]    store_rd;

  logic          meta_we;
  logic [XW-1:0] meta_wa, meta_ra;
  logic [PW-1:0] meta_wpos, meta_rpos;
  logic [OW-1:0] meta_own;
  logic          qlink_we, anext_we, aprev_we, flink_we, store_we;
  logic [XW-1:0] qlink_wa, anext_wa, aprev_wa, flink_wa;
  logic [XW-1:0] qlink_ra, anext_ra, aprev_ra, flink_ra;
  logic [BW-1:0] qlink_wd, anext_wd, aprev_wd, flink_wd;
  logic [AW-1:0] store_wa, store_ra;
  logic [7:0]    store_wd;

  logic [QIW-1:0] qi, oi;
  logic [BW-1:0]  cur_head, cur_tail;
  logic [PW-1:0]  rpos_inc;
  logic [CW-1:0]  lost;
  logic           out_load;
  logic           tail_room, pool_free;

  function automatic logic [AW-1:0] saddr(input logic [BW-1:0] blk, input logic [PW-1:0] pos);
    return AW'(blk[XW-1:0]) * AW'(BLOCK_BYTES) + AW'(pos);
  endfunction

  assign qi        = QIW'(cur.qid);
  assign oi        = QIW'(own_rd);
  assign cur_head  = head[qi];
  assign cur_tail  = tail[qi];
  assign rpos_inc  = rpos_rd + PW'(1);
  assign lost      = CW'(wpos_rd - rpos_rd);
  assign out_load  = !out_valid || !out_stall;
  assign tail_room = (cur_tail != NIL) && (wpos_rd < FULL);
  assign pool_free = (fc != '0) && (ftop != NIL);

  always_ff @(posedge clk) begin
    if (meta_we) begin
      wpos_mem[meta_wa] <= meta_wpos;
      rpos_mem[meta_wa] <= meta_rpos;
      own_mem[meta_wa]  <= meta_own;
    end
    wpos_rd <= wpos_mem[meta_ra];
    rpos_rd <= rpos_mem[meta_ra];
    own_rd  <= own_mem[meta_ra];
  end

  always_ff @(posedge clk) begin
    if (qlink_we) qlink_mem[qlink_wa] <= qlink_wd;
    qlink_rd <= qlink_mem[qlink_ra];
  end

  always_ff @(posedge clk) begin
    if (anext_we) anext_mem[anext_wa] <= anext_wd;
    anext_rd <= anext_mem[anext_ra];
  end

  always_ff @(posedge clk) begin
    if (aprev_we) aprev_mem[aprev_wa] <= aprev_wd;
    aprev_rd <= aprev_mem[aprev_ra];
  end

  always_ff @(posedge clk) begin
    if (flink_we) flink_mem[flink_wa] <= flink_wd;
    flink_rd <= flink_mem[flink_ra];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_wa] <= store_wd;
    store_rd <= store_mem[store_ra];
  end

  always_comb begin
    state_next = state;
    case (state)
      sbpq_pkg::S_CLR: if (clr == LAST) state_next = sbpq_pkg::S_IDLE;
      sbpq_pkg::S_IDLE: begin
        if (item_valid) begin
          if (!item.qok) state_next = sbpq_pkg::S_OUT;
          else begin
            case (item.op)
              sbpq_pkg::OP_WRITE: state_next = sbpq_pkg::S_W_RD;
              sbpq_pkg::OP_READ:  state_next = sbpq_pkg::S_R_RD;
              sbpq_pkg::OP_FLUSH: state_next = sbpq_pkg::S_F_RD;
              default:            state_next = sbpq_pkg::S_OUT;
            endcase
          end
        end
      end
      sbpq_pkg::S_W_RD: state_next = sbpq_pkg::S_W_CHK;
      sbpq_pkg::S_W_CHK: begin
        if (tail_room) state_next = sbpq_pkg::S_OUT;
        else if (pool_free) state_next = sbpq_pkg::S_W_POP;
        else if (oldest != NIL) state_next = sbpq_pkg::S_W_STEAL;
        else state_next = sbpq_pkg::S_OUT;
      end
      sbpq_pkg::S_W_POP:   state_next = sbpq_pkg::S_W_LINK;
      sbpq_pkg::S_W_STEAL: state_next = sbpq_pkg::S_W_LINK;
      sbpq_pkg::S_W_LINK:  state_next = sbpq_pkg::S_W_AGE;
      sbpq_pkg::S_W_AGE:   state_next = sbpq_pkg::S_OUT;
      sbpq_pkg::S_R_RD: begin
        if (cur_head == NIL) state_next = sbpq_pkg::S_OUT;
        else state_next = sbpq_pkg::S_R_CHK;
      end
      sbpq_pkg::S_R_CHK: begin
        if (rpos_rd < wpos_rd && wpos_rd <= FULL) state_next = sbpq_pkg::S_R_DATA;
        else state_next = sbpq_pkg::S_OUT;
      end
      sbpq_pkg::S_R_DATA: begin
        if (freeing) state_next = sbpq_pkg::S_F_RD;
        else state_next = sbpq_pkg::S_OUT;
      end
      sbpq_pkg::S_F_RD: begin
        if (cur_head == NIL) state_next = sbpq_pkg::S_OUT;
        else state_next = sbpq_pkg::S_F_UPD;
      end
      sbpq_pkg::S_F_UPD: begin
        if (cur.op == sbpq_pkg::OP_FLUSH) state_next = sbpq_pkg::S_F_RD;
        else state_next = sbpq_pkg::S_OUT;
      end
      sbpq_pkg::S_OUT: if (out_load) state_next = sbpq_pkg::S_IDLE;
      default: state_next = sbpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_pop  = 1'b0;
    meta_we   = 1'b0;
    meta_wa   = '0;
    meta_ra   = '0;
    meta_wpos = '0;
    meta_rpos = '0;
    meta_own  = UNOWN;
    qlink_we  = 1'b0;
    qlink_wa  = '0;
    qlink_ra  = '0;
    qlink_wd  = NIL;
    anext_we  = 1'b0;
    anext_wa  = '0;
    anext_ra  = '0;
    anext_wd  = NIL;
    aprev_we  = 1'b0;
    aprev_wa  = '0;
    aprev_ra  = '0;
    aprev_wd  = NIL;
    flink_we  = 1'b0;
    flink_wa  = '0;
    flink_ra  = '0;
    flink_wd  = NIL;
    store_we  = 1'b0;
    store_wa  = '0;
    store_ra  = '0;
    store_wd  = cur.data;
    case (state)
      sbpq_pkg::S_CLR: begin
        meta_we  = 1'b1;
        meta_wa  = clr[XW-1:0];
        flink_we = 1'b1;
        flink_wa = clr[XW-1:0];
        flink_wd = clr + BW'(1);
      end
      sbpq_pkg::S_IDLE: item_pop = item_valid;
      sbpq_pkg::S_W_RD: meta_ra = cur_tail[XW-1:0];
      sbpq_pkg::S_W_CHK: begin
        if (tail_room) begin
          store_we  = 1'b1;
          store_wa  = saddr(cur_tail, wpos_rd);
          meta_we   = 1'b1;
          meta_wa   = cur_tail[XW-1:0];
          meta_wpos = wpos_rd + PW'(1);
          meta_rpos = rpos_rd;
          meta_own  = own_rd;
        end else if (pool_free) begin
          flink_ra = ftop[XW-1:0];
        end else begin
          meta_ra  = oldest[XW-1:0];
          qlink_ra = oldest[XW-1:0];
          anext_ra = oldest[XW-1:0];
        end
      end
      sbpq_pkg::S_W_STEAL: begin
        if (anext_rd != NIL) begin
          aprev_we = 1'b1;
          aprev_wa = anext_rd[XW-1:0];
          aprev_wd = NIL;
        end
      end
      sbpq_pkg::S_W_LINK: begin
        meta_we   = 1'b1;
        meta_wa   = b[XW-1:0];
        meta_wpos = PW'(1);
        meta_rpos = '0;
        meta_own  = OW'(cur.qid);
        store_we  = 1'b1;
        store_wa  = saddr(b, '0);
        if (cur_head != NIL) begin
          qlink_we = 1'b1;
          qlink_wa = cur_tail[XW-1:0];
          qlink_wd = b;
        end
        aprev_we = 1'b1;
        aprev_wa = b[XW-1:0];
        aprev_wd = newest;
        anext_we = 1'b1;
        anext_wa = b[XW-1:0];
        anext_wd = NIL;
      end
      sbpq_pkg::S_W_AGE: begin
        if (newest != NIL) begin
          anext_we = 1'b1;
          anext_wa = newest[XW-1:0];
          anext_wd = b;
        end
      end
      sbpq_pkg::S_R_RD: meta_ra = cur_head[XW-1:0];
      sbpq_pkg::S_R_CHK: begin
        if (rpos_rd < wpos_rd && wpos_rd <= FULL) begin
          store_ra  = saddr(b, rpos_rd);
          meta_we   = 1'b1;
          meta_wa   = b[XW-1:0];
          meta_wpos = wpos_rd;
          meta_rpos = rpos_inc;
          meta_own  = own_rd;
        end
      end
      sbpq_pkg::S_F_RD: begin
        qlink_ra = cur_head[XW-1:0];
        aprev_ra = cur_head[XW-1:0];
        anext_ra = cur_head[XW-1:0];
      end
      sbpq_pkg::S_F_UPD: begin
        if (aprev_rd != NIL) begin
          anext_we = 1'b1;
          anext_wa = aprev_rd[XW-1:0];
          anext_wd = anext_rd;
        end
        if (anext_rd != NIL) begin
          aprev_we = 1'b1;
          aprev_wa = anext_rd[XW-1:0];
          aprev_wd = aprev_rd;
        end
        meta_we  = 1'b1;
        meta_wa  = b[XW-1:0];
        flink_we = 1'b1;
        flink_wa = b[XW-1:0];
        flink_wd = ftop;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbpq_pkg::S_CLR;
      clr       <= '0;
      fc        <= BW'(POOL_BLOCKS);
      ftop      <= '0;
      oldest    <= NIL;
      newest    <= NIL;
      out_valid <= 1'b0;
      for (int i = 0; i < QN; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
        cnt[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != sbpq_pkg::S_OUT) out_valid <= 1'b0;
      case (state)
        sbpq_pkg::S_CLR: clr <= clr + BW'(1);
        sbpq_pkg::S_IDLE: begin
          if (item_valid) begin
            cur     <= item;
            dropped <= 1'b0;
            rvalid  <= 1'b0;
            rbyte   <= '0;
            freeing <= 1'b0;
          end
        end
        sbpq_pkg::S_W_CHK: begin
          if (tail_room) cnt[qi] <= cnt[qi] + CW'(1);
          else if (pool_free) b <= ftop;
          else b <= oldest;
        end
        sbpq_pkg::S_W_POP: begin
          ftop <= flink_rd;
          fc   <= fc - BW'(1);
        end
        sbpq_pkg::S_W_STEAL: begin
          if (own_rd < UNOWN) begin
            cnt[oi] <= (cnt[oi] >= lost) ? cnt[oi] - lost : '0;
            if (head[oi] != NIL) begin
              if (tail[oi] == head[oi]) begin
                head[oi] <= NIL;
                tail[oi] <= NIL;
              end else begin
                head[oi] <= qlink_rd;
              end
            end
          end
          oldest <= anext_rd;
          if (anext_rd == NIL) newest <= NIL;
          dropped <= 1'b1;
        end
        sbpq_pkg::S_W_LINK: begin
          cnt[qi] <= cnt[qi] + CW'(1);
          if (cur_head == NIL) head[qi] <= b;
          tail[qi] <= b;
        end
        sbpq_pkg::S_W_AGE: begin
          if (newest == NIL) oldest <= b;
          newest <= b;
        end
        sbpq_pkg::S_R_RD: b <= cur_head;
        sbpq_pkg::S_R_CHK: begin
          if (rpos_rd < wpos_rd && wpos_rd <= FULL) begin
            rvalid  <= 1'b1;
            freeing <= (rpos_inc == wpos_rd);
            if (cnt[qi] != '0) cnt[qi] <= cnt[qi] - CW'(1);
          end
        end
        sbpq_pkg::S_R_DATA: rbyte <= store_rd;
        sbpq_pkg::S_F_RD: begin
          if (cur_head == NIL) cnt[qi] <= '0;
          else b <= cur_head;
        end
        sbpq_pkg::S_F_UPD: begin
          if (cur_tail == b) begin
            head[qi] <= NIL;
            tail[qi] <= NIL;
          end else begin
            head[qi] <= qlink_rd;
          end
          if (aprev_rd == NIL) oldest <= anext_rd;
          if (anext_rd == NIL) newest <= aprev_rd;
          ftop <= b;
          if (fc < BW'(POOL_BLOCKS)) fc <= fc + BW'(1);
        end
        sbpq_pkg::S_OUT: begin
          if (out_load) begin
            out_valid     <= 1'b1;
            read_byte     <= rbyte;
            read_valid    <= rvalid;
            queue_avail   <= cur.qok ? cnt[qi] : '0;
            queue_empty   <= cur.qok ? (cnt[qi] == '0) : 1'b1;
            free_blocks   <= fc;
            dropped_block <= dropped;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/shared_block_pool_byte_queues_core.sv =====
// ----------------------------------------------------------------------------
// shared_block_pool_byte_queues_core
// Byte queues that share a pool of blocks, with oldest-block stealing when
// the pool runs dry.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_stall | cmd, queue_id, write_byte
//  out     | out_valid/out_stall | read_byte, read_valid, queue_avail,
//          |                     | free_blocks, queue_empty, dropped_block
//
// Each transaction runs through the back-end sequencer, whose block memories
// have registered reads. Status and a bad queue id go straight to the result;
// a write takes extra states when it opens a block, a read when it drains
// its block, and a flush steps through each block the queue holds.
// After reset a clearing pass initializes the block metadata and free list.
// A two-entry command queue and the result register decouple stalls.
// ----------------------------------------------------------------------------
module shared_block_pool_byte_queues_core #(
  parameter int POOL_BLOCKS = sbpq_pkg::POOL_BLOCKS_DEF,
  parameter int BLOCK_BYTES = sbpq_pkg::BLOCK_BYTES_DEF,
  parameter int NUM_QUEUES  = sbpq_pkg::NUM_QUEUES_DEF,
  localparam int BW = $clog2(POOL_BLOCKS + 1),
  localparam int CW = $clog2(POOL_BLOCKS * BLOCK_BYTES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sbpq_pkg::CMD_W-1:0]  cmd,
  input  logic [sbpq_pkg::QID_W-1:0]  queue_id,
  input  logic [sbpq_pkg::BYTE_W-1:0] write_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbpq_pkg::BYTE_W-1:0] read_byte,
  output logic                        read_valid,
  output logic [CW-1:0]               queue_avail,
  output logic [BW-1:0]               free_blocks,
  output logic                        queue_empty,
  output logic                        dropped_block
);

  sbpq_pkg::item_t item;
  logic            item_valid;
  logic            item_pop;

  sbpq_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .queue_id   (queue_id),
    .write_byte (write_byte),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  sbpq_back #(
    .POOL_BLOCKS (POOL_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_QUEUES  (NUM_QUEUES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_byte     (read_byte),
    .read_valid    (read_valid),
    .queue_avail   (queue_avail),
    .free_blocks   (free_blocks),
    .queue_empty   (queue_empty),
    .dropped_block (dropped_block)
  );

endmodule

// ===== sim/shared_block_pool_byte_queues_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shared_block_pool_byte_queues_core_test
// Drives write, read, flush and status transactions into the byte queue core,
// predicts every result with a behavioral copy of the block pool (free list,
// age list, per-queue chains) and compares each result field by field.
// ----------------------------------------------------------------------------
module shared_block_pool_byte_queues_core_test;

  localparam int NB  = sbpq_pkg::POOL_BLOCKS_DEF;
  localparam int BB  = sbpq_pkg::BLOCK_BYTES_DEF;
  localparam int NQ  = sbpq_pkg::NUM_QUEUES_DEF;
  localparam int NIL = NB;
  localparam int BW  = $clog2(NB + 1);
  localparam int CW  = $clog2(NB * BB + 1);
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [7:0]    rbyte;
    logic          rvalid;
    logic [CW-1:0] avail;
    logic [BW-1:0] nfree;
    logic          empty;
    logic          dropped;
  } status_t;

  class pool_scoreboard;
    byte unsigned mem[int];
    int wpos[NB], rpos[NB], owner[NB], qnext[NB], anext[NB], aprev[NB], fnext[NB];
    int ftop, fcount, oldest, newest;
    int qhead[NQ], qtail[NQ], qcount[NQ];
    status_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < NB; i++) begin
        wpos[i] = 0; rpos[i] = 0; owner[i] = NQ; qnext[i] = NIL;
        anext[i] = NIL; aprev[i] = NIL; fnext[i] = i + 1;
      end
      ftop = 0; fcount = NB; oldest = NIL; newest = NIL; errors = 0;
      for (int q = 0; q < NQ; q++) begin
        qhead[q] = NIL; qtail[q] = NIL; qcount[q] = 0;
      end
    endfunction

    function void age_unlink(int b);
      int p, n;
      p = aprev[b]; n = anext[b];
      if (p < NIL) anext[p] = n; else oldest = n;
      if (n < NIL) aprev[n] = p; else newest = p;
    endfunction

    function void pop_head(int q);
      int b;
      b = qhead[q];
      if (b >= NIL) return;
      if (qtail[q] == b) begin
        qhead[q] = NIL; qtail[q] = NIL;
      end else begin
        qhead[q] = qnext[b];
      end
    endfunction

    function void release_head(int q);
      int b;
      b = qhead[q];
      if (b >= NIL) return;
      pop_head(q);
      age_unlink(b);
      owner[b] = NQ; rpos[b] = 0; wpos[b] = 0;
      fnext[b] = ftop; ftop = b;
      if (fcount < NB) fcount++;
    endfunction

    function void note_command(logic [1:0] c, logic [1:0] q, logic [7:0] d);
      status_t s;
      int t, b, o, lost;
      bit ok;
      s = '{rbyte: 8'd0, rvalid: 1'b0, avail: '0, nfree: '0, empty: 1'b1, dropped: 1'b0};
      if (c == sbpq_pkg::CMD_WRITE) begin
        ok = 1'b1;
        t = qtail[q];
        if (t >= NIL || wpos[t] >= BB) begin
          if (fcount > 0 && ftop < NIL) begin
            b = ftop; ftop = fnext[b]; fcount--;
          end else begin
            b = oldest;
            if (b < NIL) begin
              o = owner[b];
              if (o < NQ) begin
                lost = wpos[b] - rpos[b];
                qcount[o] = qcount[o] >= lost ? qcount[o] - lost : 0;
                pop_head(o);
              end
              age_unlink(b);
              rpos[b] = 0; wpos[b] = 0; s.dropped = 1'b1;
            end
          end
          if (b < NIL) begin
            owner[b] = q; qnext[b] = NIL;
            if (qhead[q] >= NIL) qhead[q] = b; else qnext[qtail[q]] = b;
            qtail[q] = b;
            aprev[b] = newest; anext[b] = NIL;
            if (newest < NIL) anext[newest] = b; else oldest = b;
            newest = b;
          end else begin
            ok = 1'b0;
          end
        end
        t = qtail[q];
        if (ok && t < NIL && wpos[t] < BB) begin
          mem[t * BB + wpos[t]] = d;
          wpos[t]++;
          qcount[q]++;
        end
      end else if (c == sbpq_pkg::CMD_READ) begin
        t = qhead[q];
        if (t < NIL && rpos[t] < wpos[t] && wpos[t] <= BB) begin
          s.rbyte = mem[t * BB + rpos[t]];
          s.rvalid = 1'b1;
          rpos[t]++;
          if (qcount[q] > 0) qcount[q]--;
          if (rpos[t] == wpos[t]) release_head(q);
        end
      end else if (c == sbpq_pkg::CMD_FLUSH) begin
        while (qhead[q] < NIL) release_head(q);
        qcount[q] = 0;
      end
      s.avail = CW'(qcount[q]);
      s.empty = (qcount[q] == 0);
      s.nfree = BW'(fcount);
      pending.push_back(s);
    endfunction

    function void check_result(status_t a);
      status_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result exp none got read_byte %0h queue_avail %0d",
                 $time, a.rbyte, a.avail);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.rbyte !== e.rbyte) begin
        $display("%0t: read_byte exp %0h got %0h", $time, e.rbyte, a.rbyte); errors++;
      end
      if (a.rvalid !== e.rvalid) begin
        $display("%0t: read_valid exp %0b got %0b", $time, e.rvalid, a.rvalid); errors++;
      end
      if (a.avail !== e.avail) begin
        $display("%0t: queue_avail exp %0d got %0d", $time, e.avail, a.avail); errors++;
      end
      if (a.nfree !== e.nfree) begin
        $display("%0t: free_blocks exp %0d got %0d", $time, e.nfree, a.nfree); errors++;
      end
      if (a.empty !== e.empty) begin
        $display("%0t: queue_empty exp %0b got %0b", $time, e.empty, a.empty); errors++;
      end
      if (a.dropped !== e.dropped) begin
        $display("%0t: dropped_block exp %0b got %0b", $time, e.dropped, a.dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [1:0] cmd = 2'd0, queue_id = 2'd0;
  logic [7:0] write_byte = 8'd0;
  logic in_stall, out_valid, read_valid, queue_empty, dropped_block;
  logic [7:0] read_byte;
  logic [CW-1:0] queue_avail;
  logic [BW-1:0] free_blocks;

  pool_scoreboard board = new();
  bit quiet = 0;
  int idle_cycles = 0;

  shared_block_pool_byte_queues_core DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result('{read_byte, read_valid, queue_avail, free_blocks, queue_empty,
                           dropped_block});
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (rst || quiet || $urandom_range(0, 15) != 0) begin
      out_stall <= 0;
    end else begin
      out_stall <= 1;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("[shared_block_pool_byte_queues_core] ERROR");
      $finish;
    end
  end

  task automatic send(logic [1:0] c, logic [1:0] q, logic [7:0] d);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1; cmd <= c; queue_id <= q; write_byte <= d;
    do @(posedge clk); while (in_stall);
    board.note_command(c, q, d);
  endtask

  task automatic pause_input();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sel, q;
    repeat (9) @(posedge clk);
    rst <= 0;
    // directed
    for (int i = 0; i < 4; i++) send(sbpq_pkg::CMD_STATUS, 2'(i), 8'hFF);
    send(sbpq_pkg::CMD_READ, 2'd0, 8'd0);
    send(sbpq_pkg::CMD_FLUSH, 2'd1, 8'd0);
    send(sbpq_pkg::CMD_WRITE, 2'd0, 8'h00);
    send(sbpq_pkg::CMD_WRITE, 2'd0, 8'hFF);
    send(sbpq_pkg::CMD_WRITE, 2'd3, 8'hA5);
    send(sbpq_pkg::CMD_WRITE, 2'd2, 8'h5A);
    send(sbpq_pkg::CMD_READ, 2'd0, 8'd0);
    send(sbpq_pkg::CMD_READ, 2'd0, 8'd0);
    send(sbpq_pkg::CMD_READ, 2'd0, 8'd0);
    send(sbpq_pkg::CMD_STATUS, 2'd3, 8'd0);
    send(sbpq_pkg::CMD_FLUSH, 2'd3, 8'd0);
    send(sbpq_pkg::CMD_FLUSH, 2'd2, 8'd0);
    pause_input();
    // fill a block and spill one byte into the next, then read both out so they free
    for (int i = 0; i < BB + 1; i++) send(sbpq_pkg::CMD_WRITE, 2'd1, 8'($urandom));
    for (int i = 0; i < BB + 2; i++) send(sbpq_pkg::CMD_READ, 2'd1, 8'd0);
    for (int i = 0; i < 6; i++) send(sbpq_pkg::CMD_READ, 2'($urandom_range(0, 3)), 8'd0);
    send(sbpq_pkg::CMD_WRITE, 2'd3, 8'($urandom));
    for (int i = 0; i < 4; i++) send(sbpq_pkg::CMD_FLUSH, 2'(i), 8'd0);
    pause_input();
    // random mix
    for (int i = 0; i < 700; i++) begin
      if (i > 560) quiet = 1;
      sel = $urandom_range(0, 99);
      q = $urandom_range(0, 3);
      if (sel < 50) send(sbpq_pkg::CMD_WRITE, 2'(q), 8'($urandom));
      else if (sel < 88) send(sbpq_pkg::CMD_READ, 2'(q), 8'($urandom));
      else if (sel < 94) send(sbpq_pkg::CMD_FLUSH, 2'(q), 8'($urandom));
      else send(sbpq_pkg::CMD_STATUS, 2'(q), 8'($urandom));
      if (i == 300) pause_input();
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[shared_block_pool_byte_queues_core] OK");
    end else begin
      $display("[shared_block_pool_byte_queues_core] ERROR");
    end
    $finish;
  end
endmodule
